### src/skts_pkg.sv
// Shared types, sizes and helpers for the sorted key table search block.
// No dependencies. Imported by every module of the block.
`default_nettype none

package skts_pkg;

  localparam int MAX_ENTRIES = 128;
  localparam int KEY_CHUNKS  = 4;
  localparam int CHUNK_W     = 64;

  localparam int ENT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W     = $clog2(MAX_ENTRIES);
  localparam int POS_W     = $clog2(KEY_CHUNKS + 1);
  localparam int CW        = (KEY_CHUNKS > 1) ? $clog2(KEY_CHUNKS) : 1;
  localparam int ADDR_W    = IDX_W + CW;
  localparam int MEM_DEPTH = MAX_ENTRIES * (2 ** CW);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [CHUNK_W-1:0] key_chunk;
    logic               chunk_last;
  } in_item_t;

  typedef struct packed {
    logic       found;
    logic [6:0] match_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic fill_wr;
    logic search_init;
    logic pick;
    logic step_chunk;
    logic narrow;
    logic res_hit;
    logic res_miss;
    logic out_load;
  } dp_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic fill_req;
    logic search_req;
    logic fill_last;
    logic range_empty;
    logic chunk_eq;
    logic chunk_final;
  } dp_sts_t;

  // Zero the first zero byte and everything after it
  function automatic logic [CHUNK_W-1:0] cut_chunk(input logic [CHUNK_W-1:0] c,
                                                   input logic ended);
    logic [CHUNK_W-1:0] res;
    logic               done;
    res  = '0;
    done = ended;
    for (int i = 7; i >= 0; i--) begin
      if (done || c[8*i +: 8] == 8'h00) begin
        done = 1'b1;
      end else begin
        res[8*i +: 8] = c[8*i +: 8];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### src/skts_dp.sv
// Datapath: key store memory, query buffer, append/query chunk tracking,
// search range registers, chunk compare and output register. Uses skts_pkg.
`default_nettype none

module skts_dp import skts_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_item_i,
  input  wire logic      cfg_valid_i,
  input  wire logic      cfg_ready_i,
  input  wire logic      cfg_data_i,
  input  wire dp_ctl_t   ctl_i,
  output dp_sts_t        sts_o,
  output out_item_t      out_item_o
);

  logic [CHUNK_W-1:0] mem_q [MEM_DEPTH];
  logic [CHUNK_W-1:0] rd_data_q;
  logic [CHUNK_W-1:0] qbuf_q [KEY_CHUNKS];

  logic [POS_W-1:0] apos_q, apos_d, qpos_q, fill_pos_q;
  logic             aend_q, qend_q;
  logic [ENT_W-1:0] total_q, total_d, lo_q, hi_q;
  logic [IDX_W-1:0] cur_q, res_idx_q;
  logic [CW-1:0]    k_q;
  logic             res_found_q;
  logic             mode_q;
  out_item_t        out_q;

  logic               is_clear, is_append, is_query;
  logic               full, app_wr, q_wr;
  logic [CHUNK_W-1:0] app_cut, q_cut, qk;
  logic               mem_we;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [CHUNK_W-1:0] wr_data;
  logic [ENT_W:0]     mid_sum;
  logic [IDX_W-1:0]   mid;

  assign is_clear  = ctl_i.accept && in_item_i.cmd == CMD_CLEAR;
  assign is_append = ctl_i.accept && in_item_i.cmd == CMD_APPEND;
  assign is_query  = ctl_i.accept && in_item_i.cmd == CMD_QUERY;

  assign full    = total_q == ENT_W'(MAX_ENTRIES);
  assign app_wr  = is_append && !full && apos_q < POS_W'(KEY_CHUNKS);
  assign q_wr    = is_query && qpos_q < POS_W'(KEY_CHUNKS);
  assign app_cut = cut_chunk(in_item_i.key_chunk, apos_q != '0 && aend_q);
  assign q_cut   = cut_chunk(in_item_i.key_chunk, qpos_q != '0 && qend_q);
  assign apos_d  = app_wr ? apos_q + 1'b1 : apos_q;

  assign sts_o.fill_req    = is_append && in_item_i.chunk_last && !full &&
                             apos_d < POS_W'(KEY_CHUNKS);
  assign sts_o.search_req  = is_query && in_item_i.chunk_last;
  assign sts_o.fill_last   = fill_pos_q == POS_W'(KEY_CHUNKS - 1);
  assign sts_o.range_empty = lo_q >= hi_q;
  assign qk                = qbuf_q[k_q];
  assign sts_o.chunk_eq    = qk == rd_data_q;
  assign sts_o.chunk_final = k_q == CW'(KEY_CHUNKS - 1);

  assign mem_we  = app_wr || ctl_i.fill_wr;
  assign wr_addr = app_wr ? {total_q[IDX_W-1:0], apos_q[CW-1:0]}
                          : {total_q[IDX_W-1:0], fill_pos_q[CW-1:0]};
  assign wr_data = app_wr ? app_cut : '0;
  assign rd_addr = {cur_q, k_q};

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q} - 1'b1;
  assign mid     = mode_q ? IDX_W'(mid_sum[ENT_W:1]) : IDX_W'(lo_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_comb begin
    total_d = total_q;
    if (is_clear) begin
      total_d = '0;
    end else if (is_append && in_item_i.chunk_last && !full &&
                 apos_d == POS_W'(KEY_CHUNKS)) begin
      total_d = total_q + 1'b1;
    end else if (ctl_i.fill_wr && sts_o.fill_last) begin
      total_d = total_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      apos_q  <= '0;
      qpos_q  <= '0;
      aend_q  <= 1'b0;
      qend_q  <= 1'b0;
      mode_q  <= 1'b1;
    end else begin
      total_q <= total_d;
      if (cfg_valid_i && cfg_ready_i) begin
        mode_q <= cfg_data_i;
      end
      if (is_clear) begin
        apos_q <= '0;
        qpos_q <= '0;
      end
      if (is_append) begin
        apos_q <= in_item_i.chunk_last ? '0 : apos_d;
        if (app_wr) begin
          aend_q <= app_cut[7:0] == 8'h00;
        end
      end
      if (is_query) begin
        if (in_item_i.chunk_last) begin
          qpos_q <= '0;
        end else if (q_wr) begin
          qpos_q <= qpos_q + 1'b1;
        end
        if (q_wr) begin
          qend_q <= q_cut[7:0] == 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_query) begin
      for (int k = 0; k < KEY_CHUNKS; k++) begin
        if (POS_W'(k) == qpos_q) begin
          qbuf_q[k] <= q_cut;
        end else if (in_item_i.chunk_last && POS_W'(k) > qpos_q) begin
          qbuf_q[k] <= '0;
        end
      end
    end
    if (is_append) begin
      fill_pos_q <= apos_d;
    end else if (ctl_i.fill_wr) begin
      fill_pos_q <= fill_pos_q + 1'b1;
    end
    if (ctl_i.search_init) begin
      lo_q <= '0;
      hi_q <= total_q;
    end
    if (ctl_i.pick) begin
      cur_q <= mid;
      k_q   <= '0;
    end
    if (ctl_i.step_chunk) begin
      k_q <= k_q + 1'b1;
    end
    if (ctl_i.narrow) begin
      if (mode_q && qk < rd_data_q) begin
        hi_q <= ENT_W'(cur_q);
      end else begin
        lo_q <= ENT_W'(cur_q) + 1'b1;
      end
    end
    if (ctl_i.res_hit) begin
      res_found_q <= 1'b1;
      res_idx_q   <= cur_q;
    end
    if (ctl_i.res_miss) begin
      res_found_q <= 1'b0;
      res_idx_q   <= '0;
    end
    if (ctl_i.out_load) begin
      out_q.found       <= res_found_q;
      out_q.match_index <= 7'(res_idx_q);
    end
  end

  assign out_item_o = out_q;

endmodule

`default_nettype wire

### src/skts_ctrl.sv
// Controller state machine: input acceptance, zero fill of short entries,
// search sequencing and output valid. Uses skts_pkg; drives skts_dp.
`default_nettype none

module skts_ctrl import skts_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_stall_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  input  wire dp_sts_t sts_i,
  output dp_ctl_t      ctl_o
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FILL  = 6'b000010,
    ST_SINIT = 6'b000100,
    ST_PICK  = 6'b001000,
    ST_RD    = 6'b010000,
    ST_CMP   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   done_q, done_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign in_stall_o  = state_q != ST_IDLE || done_q;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && out_stall_i;
    ctl_o       = '0;
    if (done_q && out_free) begin
      ctl_o.out_load = 1'b1;
      out_valid_d    = 1'b1;
      done_d         = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !done_q) begin
          ctl_o.accept = 1'b1;
          if (sts_i.fill_req) begin
            state_d = ST_FILL;
          end else if (sts_i.search_req) begin
            state_d = ST_SINIT;
          end
        end
      end
      ST_FILL: begin
        ctl_o.fill_wr = 1'b1;
        if (sts_i.fill_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_SINIT: begin
        ctl_o.search_init = 1'b1;
        state_d           = ST_PICK;
      end
      ST_PICK: begin
        if (sts_i.range_empty) begin
          ctl_o.res_miss = 1'b1;
          done_d         = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          ctl_o.pick = 1'b1;
          state_d    = ST_RD;
        end
      end
      ST_RD: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (!sts_i.chunk_eq) begin
          ctl_o.narrow = 1'b1;
          state_d      = ST_PICK;
        end else if (sts_i.chunk_final) begin
          ctl_o.res_hit = 1'b1;
          done_d        = 1'b1;
          state_d       = ST_IDLE;
        end else begin
          ctl_o.step_chunk = 1'b1;
          state_d          = ST_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### src/sorted_key_table_search.sv
// Top level of the sorted key table search block.
// Instantiates skts_ctrl and skts_dp; uses skts_pkg.
//
// Keeps a table of up to MAX_ENTRIES text keys of KEY_CHUNKS 64-bit chunks
// each and answers lookups. Input channel (in_valid_i/in_stall_o) carries
// one chunk per transaction with a command: clear, append or query. The
// result channel (out_valid_o/out_stall_i) gives found and match_index once
// per query, on the transaction marked chunk_last.
// cfg_valid_i/cfg_ready_o writes search_mode: 0 first-match scan in load
// order, 1 binary search over a table kept in ascending order.
// Clear and most chunks are taken without a stall. An append ending short
// of KEY_CHUNKS chunks stalls the input while the missing chunks are zero
// filled. A final query chunk starts a search that probes entries (up to
// the entry count in scan mode, about log2 of it in binary mode), each
// probe reading and comparing chunks one at a time from the single-port key
// memory with registered read until a chunk differs or all have matched.
// A miss ends the search once the search range is empty.
// A finished result waits in the output register while new transactions
// are taken; a further result holds the input stalled until it is free.
// Reset empties the table and selects binary search; no clearing pass.
`default_nettype none

module sorted_key_table_search import skts_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_item_t  in_item_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_item_t      out_item_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire logic      cfg_data_i
);

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  skts_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .ctl_o       (ctl)
  );

  skts_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

### src/skts_chk.sv
// Port-level checker for sorted_key_table_search, bound to the top level.
// Uses skts_pkg types.
`default_nettype none

module skts_chk import skts_pkg::*; (
  input wire logic      clk_i,
  input wire logic      rst_ni,
  input wire logic      in_valid_i,
  input wire logic      in_stall_o,
  input wire in_item_t  in_item_i,
  input wire logic      out_valid_o,
  input wire logic      out_stall_i,
  input wire out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.found |-> out_item_o.match_index == 7'd0)
    else $error("miss with non-zero index");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.cmd == CMD_QUERY && in_item_i.chunk_last
    |=> in_stall_o)
    else $error("input not stalled during search");

  a_result_after_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a search");

endmodule

bind sorted_key_table_search skts_chk u_skts_chk (.*);

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for sorted_key_table_search: drives clear, append and query
// chunks with random gaps and stalls, and predicts each lookup result in a local table model.
// Depends on skts_pkg and the RTL under src/.
module tb_top;
  import skts_pkg::*;

  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam int         KEY_BYTES  = KEY_CHUNKS * 8;
  localparam int         IDLE_LIMIT = 20000;
  localparam int         SETTLE     = 16;

  typedef logic [KEY_CHUNKS*CHUNK_W-1:0] key_t;  // chunk 0 in the top bits

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic      cfg_data_i  = 1'b0;

  sorted_key_table_search i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Table model
  logic [CHUNK_W-1:0] stored_keys [MAX_ENTRIES][KEY_CHUNKS];
  logic [CHUNK_W-1:0] probe_key [KEY_CHUNKS];
  int                 entries   = 0;
  int                 fill_pos  = 0;
  int                 probe_pos = 0;
  logic               bin_mode  = 1'b1;
  out_item_t          pending_answers[$];

  // Run bookkeeping
  int   items_done   = 0;
  int   queries_done = 0;
  int   hits_seen    = 0;
  int   peak_entries = 0;
  int   mode_writes  = 0;
  int   fail_count   = 0;
  int   idle_cycles  = 0;
  int   sink_hold;
  int   stall_left   = 0;
  logic calm         = 1'b0;

  key_t roster [MAX_ENTRIES+4];
  int   roster_n = 0;

  function automatic logic [CHUNK_W-1:0] trim_at_nul(logic [CHUNK_W-1:0] c, logic ended);
    logic [CHUNK_W-1:0] r;
    logic               stop;
    r    = '0;
    stop = ended;
    for (int b = 7; b >= 0; b--) begin
      if (c[8*b +: 8] == 8'h00) stop = 1'b1;
      if (!stop) r[8*b +: 8] = c[8*b +: 8];
    end
    return r;
  endfunction

  function automatic int order_vs(int e);
    for (int k = 0; k < KEY_CHUNKS; k++) begin
      if (probe_key[k] < stored_keys[e][k]) return -1;
      if (probe_key[k] > stored_keys[e][k]) return 1;
    end
    return 0;
  endfunction

  function automatic int locate_probe();
    int lo, hi, mid, r;
    if (!bin_mode) begin
      for (int i = 0; i < entries; i++)
        if (order_vs(i) == 0) return i;
      return -1;
    end
    lo = 0;
    hi = entries - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      r   = order_vs(mid);
      if (r == 0) return mid;
      if (r < 0) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic void advance_table(in_item_t it);
    logic      ended;
    int        idx;
    out_item_t ans;
    case (it.cmd)
      CMD_CLEAR: begin
        entries   = 0;
        fill_pos  = 0;
        probe_pos = 0;
      end
      CMD_APPEND: begin
        if (entries < MAX_ENTRIES) begin
          if (fill_pos < KEY_CHUNKS) begin
            ended = (fill_pos > 0) && (stored_keys[entries][fill_pos-1][7:0] == 8'h00);
            stored_keys[entries][fill_pos] = trim_at_nul(it.key_chunk, ended);
            fill_pos++;
          end
          if (it.chunk_last) begin
            while (fill_pos < KEY_CHUNKS) begin
              stored_keys[entries][fill_pos] = '0;
              fill_pos++;
            end
            entries++;
            if (entries > peak_entries) peak_entries = entries;
          end
        end
        if (it.chunk_last) fill_pos = 0;
      end
      CMD_QUERY: begin
        if (probe_pos < KEY_CHUNKS) begin
          ended = (probe_pos > 0) && (probe_key[probe_pos-1][7:0] == 8'h00);
          probe_key[probe_pos] = trim_at_nul(it.key_chunk, ended);
          probe_pos++;
        end
        if (it.chunk_last) begin
          while (probe_pos < KEY_CHUNKS) begin
            probe_key[probe_pos] = '0;
            probe_pos++;
          end
          probe_pos = 0;
          idx = locate_probe();
          ans = '0;
          if (idx >= 0) begin
            ans.found       = 1'b1;
            ans.match_index = idx[6:0];
            hits_seen++;
          end
          pending_answers.push_back(ans);
          queries_done++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int key_len(key_t k);
    int n;
    n = 0;
    while (n < KEY_BYTES && k[8*(KEY_BYTES-1-n) +: 8] != 8'h00) n++;
    return n;
  endfunction

  function automatic key_t fresh_key();
    key_t k;
    int   len;
    k   = '0;
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, KEY_BYTES) : $urandom_range(0, 8);
    for (int p = 0; p < len; p++) k[8*(KEY_BYTES-1-p) +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  // change, or append, one character
  function automatic key_t near_key(key_t k);
    int len, p;
    len = key_len(k);
    p   = (len == KEY_BYTES) ? $urandom_range(0, len - 1) : $urandom_range(0, len);
    k[8*(KEY_BYTES-1-p) +: 8] = 8'($urandom_range(1, 255));
    return k;
  endfunction

  function automatic void report_mismatch(string what, out_item_t exp, out_item_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("%0t mismatch, %s: expected found=%0b index=%0d, got found=%0b index=%0d",
               $realtime, what, exp.found, exp.match_index, got.found, got.match_index);
  endfunction

  task automatic send_item(logic [1:0] op, logic [CHUNK_W-1:0] c, logic lst);
    in_item_t it;
    int       gap;
    it.cmd        = op;
    it.key_chunk  = c;
    it.chunk_last = lst;
    gap = calm ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    advance_table(it);
    if (op != CMD_SPARE) items_done++;
  endtask

  task automatic send_key(logic [1:0] op, key_t k, logic mangle);
    key_t               raw;
    logic [CHUNK_W-1:0] c;
    int                 len, need, count;
    len   = key_len(k);
    need  = (len == 0) ? 1 : (len + 7) / 8;
    raw   = k;
    count = need;
    if (mangle) begin
      // junk after the terminator, and sometimes chunks beyond the key size
      for (int p = len + 1; p < KEY_BYTES; p++) raw[8*(KEY_BYTES-1-p) +: 8] = 8'($urandom);
      count = $urandom_range(need, KEY_CHUNKS + 2);
    end
    for (int j = 0; j < count; j++) begin
      c = (j < KEY_CHUNKS) ? raw[CHUNK_W*(KEY_CHUNKS-1-j) +: CHUNK_W] : {$urandom, $urandom};
      send_item(op, c, j == count - 1);
    end
  endtask

  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_mode(logic m);
    wait_quiet();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    bin_mode = m;
    mode_writes++;
  endtask

  task automatic append_roster();
    for (int i = 0; i < roster_n; i++)
      send_key(CMD_APPEND, roster[i], 1'($urandom_range(0, 1)));
  endtask

  task automatic ask_keys(int q);
    key_t k;
    for (int i = 0; i < q; i++) begin
      if (roster_n > 0 && $urandom_range(0, 9) < 7)
        k = roster[$urandom_range(0, roster_n - 1)];
      else if (roster_n > 0 && $urandom_range(0, 1) == 1)
        k = near_key(roster[$urandom_range(0, roster_n - 1)]);
      else
        k = fresh_key();
      send_key(CMD_QUERY, k, 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_directed();
    // binary mode and an empty table straight out of reset
    send_item(CMD_QUERY, '0, 1'b1);
    send_item(CMD_SPARE, '1, 1'b1);
    send_item(CMD_APPEND, 64'h4100_0000_0000_0000, 1'b1);
    send_item(CMD_APPEND, 64'h4142_00FF_1234_5678, 1'b0);
    send_item(CMD_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    for (int j = 0; j < KEY_CHUNKS; j++) send_item(CMD_APPEND, '1, j == KEY_CHUNKS - 1);
    send_item(CMD_QUERY, 64'h4142_0000_0000_0001, 1'b1);
    for (int j = 0; j < KEY_CHUNKS + 2; j++) send_item(CMD_QUERY, '1, j == KEY_CHUNKS + 1);
    send_item(CMD_QUERY, 64'h4100_0000_0000_0000, 1'b0);
    send_item(CMD_QUERY, '1, 1'b1);
    send_item(CMD_CLEAR, '1, 1'b0);
    send_item(CMD_QUERY, 64'h4100_0000_0000_0000, 1'b1);
    // duplicates and the empty key in scan mode
    set_mode(1'b0);
    send_item(CMD_APPEND, 64'h4200_0000_0000_0000, 1'b1);
    send_item(CMD_APPEND, 64'h4200_0000_0000_0000, 1'b1);
    send_item(CMD_APPEND, '0, 1'b1);
    send_item(CMD_QUERY, 64'h4200_0000_0000_0000, 1'b1);
    send_item(CMD_QUERY, '0, 1'b1);
  endtask

  task automatic test_binary_sorted(int quota);
    key_t k;
    int   stop_at, round, n, j;
    set_mode(1'b1);
    stop_at = items_done + quota;
    round   = 0;
    while (items_done < stop_at) begin
      calm = ($urandom_range(0, 3) == 0);
      send_item(CMD_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      n = (round == 1) ? MAX_ENTRIES : $urandom_range(1, 20);
      for (int i = 0; i < n; i++)
        roster[i] = (i > 0 && $urandom_range(0, 1) == 1) ?
                    near_key(roster[$urandom_range(0, i - 1)]) : fresh_key();
      for (int i = 1; i < n; i++) begin
        k = roster[i];
        j = i - 1;
        while (j >= 0 && roster[j] > k) begin
          roster[j+1] = roster[j];
          j--;
        end
        roster[j+1] = k;
      end
      roster_n = n;
      append_roster();
      if (n == MAX_ENTRIES) begin
        // table full: these are dropped
        send_key(CMD_APPEND, fresh_key(), 1'b1);
        send_key(CMD_APPEND, fresh_key(), 1'b1);
      end
      ask_keys($urandom_range(3, 10));
      if (round % 4 == 2) wait_quiet();
      round++;
    end
    calm = 1'b0;
  endtask

  task automatic test_linear_scan(int quota);
    key_t pool [6];
    int   stop_at, round, n;
    set_mode(1'b0);
    stop_at = items_done + quota;
    round   = 0;
    while (items_done < stop_at) begin
      calm = ($urandom_range(0, 3) == 0);
      send_item(CMD_CLEAR, {$urandom, $urandom}, 1'($urandom_range(0, 1)));
      for (int p = 0; p < 6; p++)
        pool[p] = (p > 0 && $urandom_range(0, 1) == 1) ? near_key(pool[p-1]) : fresh_key();
      n = (round == 1) ? MAX_ENTRIES + 2 : $urandom_range(0, 16);
      for (int i = 0; i < n; i++) roster[i] = pool[$urandom_range(0, 5)];
      roster_n = n;
      append_roster();
      ask_keys($urandom_range(3, 8));
      if (round % 5 == 3) wait_quiet();
      round++;
    end
    calm = 1'b0;
  endtask

  task automatic test_noise(int quota);
    logic [CHUNK_W-1:0] c;
    int                 stop_at, pick;
    stop_at = items_done + quota;
    while (items_done < stop_at) begin
      if ($urandom_range(0, 59) == 0) set_mode(1'($urandom_range(0, 1)));
      if ($urandom_range(0, 39) == 0) calm = !calm;
      pick = $urandom_range(0, 19);
      c    = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1) c[8*$urandom_range(0, 7) +: 8] = 8'h00;
      if (pick == 0)
        send_item(CMD_CLEAR, c, 1'($urandom_range(0, 1)));
      else if (pick == 1)
        send_item(CMD_SPARE, c, 1'($urandom_range(0, 1)));
      else if (pick < 5)
        send_key(CMD_APPEND, fresh_key(), 1'($urandom_range(0, 1)));
      else if (pick < 8)
        send_key(CMD_QUERY, (roster_n > 0 && $urandom_range(0, 1) == 1) ?
                 roster[$urandom_range(0, roster_n - 1)] : fresh_key(),
                 1'($urandom_range(0, 1)));
      else if (pick < 14)
        send_item(CMD_APPEND, c, $urandom_range(0, 2) == 0);
      else
        send_item(CMD_QUERY, c, $urandom_range(0, 2) == 0);
    end
    calm = 1'b0;
  endtask

  // result side: random stall per transaction, checked against the oldest prediction
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing outstanding", '0, out_item_o);
      end else begin
        if (out_item_o.found !== pending_answers[0].found)
          report_mismatch("found", pending_answers[0], out_item_o);
        else if (out_item_o.match_index !== pending_answers[0].match_index)
          report_mismatch("match_index", pending_answers[0], out_item_o);
        void'(pending_answers.pop_front());
      end
      sink_hold = calm ? 0 : $urandom_range(0, 16);
      if (sink_hold == 0) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b1;
        stall_left  <= sink_hold;
      end
    end else if (out_valid_o && out_stall_i) begin
      if (stall_left <= 1) out_stall_i <= 1'b0;
      else stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_binary_sorted(550);
    test_linear_scan(400);
    test_noise(380);
    wait_quiet();
    $display("Covered %0d input transactions and %0d lookups (%0d hits), peak table %0d",
             items_done, queries_done, hits_seen, peak_entries);
    $display("entries, %0d mode writes, %0d mismatches", mode_writes, fail_count);
    if (fail_count == 0 && pending_answers.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
